[rtl/rms_pkg.sv]
// Shared types, sizes and codes for the running median set.
package rms_pkg;

	localparam int CAPACITY = 64;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int VAL_W    = 32;
	localparam int ECNT_W   = 7;

	localparam logic [1:0] REQ_INSERT = 2'd0;
	localparam logic [1:0] REQ_REMOVE = 2'd1;
	localparam logic [1:0] REQ_QUERY  = 2'd2;

	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_FULL   = 2'd1;
	localparam logic [1:0] ST_ABSENT = 2'd2;
	localparam logic [1:0] ST_EMPTY  = 2'd3;

	// Broadcast to every cell in the row.
	typedef struct packed {
		logic                    ins;
		logic                    rem;
		logic signed [VAL_W-1:0] key;
		logic [CNT_W-1:0]        count;
	} rms_cell_ctrl_t;

	// Per-cell compare results against the broadcast key.
	typedef struct packed {
		logic gt;
		logic ge;
		logic eq;
	} rms_cell_flags_t;

endpackage

[rtl/rms_cell.sv]
// One slot of the sorted row: compares against the key and shifts left or right.
module rms_cell import rms_pkg::*; (
	input  logic                    clk,
	input  logic [IDX_W-1:0]        idx,
	input  rms_cell_ctrl_t          ctrl,
	input  logic signed [VAL_W-1:0] left_val,
	input  logic                    left_gt,
	input  logic signed [VAL_W-1:0] right_val,
	output logic signed [VAL_W-1:0] val,
	output rms_cell_flags_t         flags
);

	logic signed [VAL_W-1:0] val_q;
	logic                    occupied;
	logic                    at_end;

	assign occupied = {1'b0, idx} < ctrl.count;
	assign at_end   = {1'b0, idx} == ctrl.count;

	assign flags.gt = occupied && (val_q > ctrl.key);
	assign flags.ge = occupied && (val_q >= ctrl.key);
	assign flags.eq = occupied && (val_q == ctrl.key);
	assign val      = val_q;

	always_ff @(posedge clk) begin
		if (ctrl.ins) begin
			// cells past the insertion point take their left neighbor
			if (left_gt) begin
				val_q <= left_val;
			end else if (flags.gt || at_end) begin
				val_q <= ctrl.key;
			end
		end else if (ctrl.rem) begin
			// from the first copy of the key on, pull the right neighbor in
			if (flags.ge) begin
				val_q <= right_val;
			end
		end
	end

endmodule

[rtl/rms_median_sel.sv]
// Picks the lower and upper median out of the sorted row by one-hot select.
module rms_median_sel import rms_pkg::*; (
	input  logic signed [VAL_W-1:0] vals [CAPACITY],
	input  logic [CNT_W-1:0]        count,
	output logic signed [VAL_W-1:0] lo,
	output logic signed [VAL_W-1:0] hi
);

	logic [CNT_W-1:0] cnt_m1;
	logic [IDX_W-1:0] lo_idx;
	logic [IDX_W-1:0] hi_idx;

	assign cnt_m1 = count - CNT_W'(1);
	assign lo_idx = IDX_W'(cnt_m1 >> 1);
	assign hi_idx = IDX_W'(count >> 1);

	always_comb begin
		lo = '0;
		hi = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			if (lo_idx == IDX_W'(i)) lo = lo | vals[i];
			if (hi_idx == IDX_W'(i)) hi = hi | vals[i];
		end
	end

endmodule

[rtl/running_median_set.sv]
// Running median set: sorted row of cells with insert, remove and median query.
// A transfer at start sets busy (sel_q); done is registered from busy (done_q).
// No new item is taken while busy is high; the row shifts in the accept cycle,
// and the median select and compare run while busy is high.
// Reset clears the count and control only; cell contents are unused until written.
// Results cannot be stalled: done is high for exactly one cycle per item.
module running_median_set import rms_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  logic [1:0]               req_type,
	input  logic signed [VAL_W-1:0]  value,
	output logic                     done,
	output logic [1:0]               status,
	output logic signed [VAL_W-1:0]  median_low,
	output logic signed [VAL_W-1:0]  median_high,
	output logic                     in_middle,
	output logic [ECNT_W-1:0]        element_count
);

	logic                    accept;
	logic                    full;
	logic                    found;
	logic                    do_ins;
	logic                    do_rem;
	logic [1:0]              st_next;
	logic [CNT_W-1:0]        count_q;
	logic                    sel_q;
	logic                    done_q;
	logic [1:0]              status_q;
	logic signed [VAL_W-1:0] key_q;
	logic signed [VAL_W-1:0] med_lo;
	logic signed [VAL_W-1:0] med_hi;
	logic [1:0]              status_o_q;
	logic signed [VAL_W-1:0] lo_o_q;
	logic signed [VAL_W-1:0] hi_o_q;
	logic                    mid_o_q;
	logic [CNT_W-1:0]        count_o_q;
	logic [CAPACITY-1:0]     eq_vec;
	rms_cell_ctrl_t          ctrl;
	rms_cell_flags_t         flags [CAPACITY];
	logic signed [VAL_W-1:0] vals  [CAPACITY];

	assign accept = start && !sel_q;
	assign busy   = sel_q;
	assign full   = count_q >= CNT_W'(CAPACITY);

	always_comb begin
		for (int i = 0; i < CAPACITY; i++) begin
			eq_vec[i] = flags[i].eq;
		end
	end
	assign found = |eq_vec;

	always_comb begin
		do_ins  = 1'b0;
		do_rem  = 1'b0;
		st_next = ST_OK;
		case (req_type)
			REQ_INSERT: begin
				if (full) st_next = ST_FULL;
				else do_ins = accept;
			end
			REQ_REMOVE: begin
				if (!found) st_next = ST_ABSENT;
				else do_rem = accept;
			end
			default: begin
				// query and the unused code leave the row untouched
			end
		endcase
	end

	// key broadcast comes straight from the port during the accept cycle
	assign ctrl.ins   = do_ins;
	assign ctrl.rem   = do_rem;
	assign ctrl.key   = sel_q ? key_q : value;
	assign ctrl.count = count_q;

	for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
		logic signed [VAL_W-1:0] lv;
		logic                    lg;
		logic signed [VAL_W-1:0] rv;
		if (g == 0) begin : g_first
			assign lv = value;
			assign lg = 1'b0;
		end else begin : g_mid
			assign lv = vals[g-1];
			assign lg = flags[g-1].gt;
		end
		if (g == CAPACITY - 1) begin : g_last
			assign rv = vals[g];
		end else begin : g_body
			assign rv = vals[g+1];
		end
		rms_cell u_cell (
			.clk       (clk),
			.idx       (IDX_W'(g)),
			.ctrl      (ctrl),
			.left_val  (lv),
			.left_gt   (lg),
			.right_val (rv),
			.val       (vals[g]),
			.flags     (flags[g])
		);
	end

	rms_median_sel u_sel (
		.vals  (vals),
		.count (count_q),
		.lo    (med_lo),
		.hi    (med_hi)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			sel_q   <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			done_q <= sel_q;
			if (accept) begin
				sel_q <= 1'b1;
				if (do_ins) count_q <= count_q + CNT_W'(1);
				else if (do_rem) count_q <= count_q - CNT_W'(1);
			end else if (sel_q) begin
				sel_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			key_q    <= value;
			status_q <= st_next;
		end
		if (sel_q) begin
			count_o_q <= count_q;
			if (count_q == '0) begin
				status_o_q <= (status_q == ST_OK) ? ST_EMPTY : status_q;
				lo_o_q     <= '0;
				hi_o_q     <= '0;
				mid_o_q    <= 1'b0;
			end else begin
				status_o_q <= status_q;
				lo_o_q     <= med_lo;
				hi_o_q     <= med_hi;
				mid_o_q    <= (med_lo <= key_q) && (key_q <= med_hi);
			end
		end
	end

	assign done          = done_q;
	assign status        = status_o_q;
	assign median_low    = lo_o_q;
	assign median_high   = hi_o_q;
	assign in_middle     = mid_o_q;
	assign element_count = ECNT_W'(count_o_q);

endmodule
